/* hdl/buffer_pool_free_ring_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef BUFFER_POOL_FREE_RING_TOP_ASSERT_SVH
`define BUFFER_POOL_FREE_RING_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPFR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPFR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bpfr_pkg.sv */
// ----------------------------------------------------------------------------
// bpfr_pkg
// Shared types and codes of the buffer pool free ring.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfr_pkg;

  localparam int OP_W    = 2;
  localparam int BIDX_W  = 8;
  localparam int ST_W    = 3;
  localparam int GRANT_W = 4;
  localparam int OUTS_W  = 5;

  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RETURN  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_CLOSING = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_OUT = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BIDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [GRANT_W-1:0] granted_index;
    logic [OUTS_W-1:0]  outstanding;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/bpfr_ram.sv */
// ----------------------------------------------------------------------------
// bpfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/bpfr_ctrl.sv */
// ----------------------------------------------------------------------------
// bpfr_ctrl
// Pool state: free ring, checkout marks, counters and closing flag.
// Executes one request per fire and returns its result word.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfr_ctrl #(
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire bpfr_pkg::req_t req,
  output bpfr_pkg::rsp_t     rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] ring_head, ring_head_next;
  logic [IDX_W-1:0] ring_tail, ring_tail_next;
  logic [CNT_W-1:0] free_total, free_total_next;
  logic [CNT_W-1:0] taken_total, taken_total_next;
  logic [DEPTH-1:0] taken_mark, taken_mark_next;
  logic             closing, closing_next;
  // ring entry written since reset; an unwritten entry reads as its own position
  logic [DEPTH-1:0] ring_vld;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] ram_q;

  // prefetch of the entry at the ring head
  logic [IDX_W-1:0] pf_addr;
  logic             pf_vld;
  logic             pf_byp;
  logic [IDX_W-1:0] pf_byp_data;
  logic [IDX_W-1:0] head_entry;
  logic [IDX_W-1:0] ret_idx;
  logic             ret_unknown;

  assign head_entry  = pf_byp ? pf_byp_data : (pf_vld ? ram_q : pf_addr);
  assign ret_idx     = req.block_index[IDX_W-1:0];
  assign ret_unknown = {1'b0, req.block_index} >= (bpfr_pkg::BIDX_W + 1)'(DEPTH);

  always_comb begin
    ring_head_next   = ring_head;
    ring_tail_next   = ring_tail;
    free_total_next  = free_total;
    taken_total_next = taken_total;
    taken_mark_next  = taken_mark;
    closing_next     = closing;
    wr_en            = 1'b0;
    wr_addr          = ring_tail;
    wr_data          = ret_idx;
    rsp.status       = bpfr_pkg::ST_OK;
    rsp.granted_index = '0;

    case (req.operation)
      bpfr_pkg::OP_ACQUIRE: begin
        if (closing) begin
          rsp.status = bpfr_pkg::ST_CLOSING;
        end else if (free_total == '0) begin
          rsp.status = bpfr_pkg::ST_EMPTY;
        end else begin
          // pop stands even when the entry turns out stale
          ring_head_next  = (ring_head == LAST_POS) ? '0 : ring_head + IDX_W'(1);
          free_total_next = free_total - CNT_W'(1);
          if (taken_mark[head_entry]) begin
            rsp.status = bpfr_pkg::ST_EMPTY;
          end else begin
            taken_mark_next[head_entry] = 1'b1;
            taken_total_next  = taken_total + CNT_W'(1);
            rsp.granted_index = bpfr_pkg::GRANT_W'(head_entry);
          end
        end
      end
      bpfr_pkg::OP_RETURN: begin
        if (closing) begin
          rsp.status = bpfr_pkg::ST_CLOSING;
        end else if (ret_unknown) begin
          rsp.status = bpfr_pkg::ST_UNKNOWN;
        end else if (!taken_mark[ret_idx] || taken_total == '0) begin
          rsp.status = bpfr_pkg::ST_NOT_OUT;
        end else begin
          taken_mark_next[ret_idx] = 1'b0;
          taken_total_next = taken_total - CNT_W'(1);
          // full ring: mark free, drop the push
          if (free_total < FULL_CNT) begin
            wr_en           = 1'b1;
            ring_tail_next  = (ring_tail == LAST_POS) ? '0 : ring_tail + IDX_W'(1);
            free_total_next = free_total + CNT_W'(1);
          end
        end
      end
      bpfr_pkg::OP_CLOSE: begin
        closing_next = 1'b1;
      end
      default: begin
      end
    endcase

    rsp.outstanding = bpfr_pkg::OUTS_W'(taken_total_next);
  end

  assign rd_addr = fire ? ring_head_next : ring_head;

  bpfr_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (fire && wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head   <= '0;
      ring_tail   <= '0;
      free_total  <= FULL_CNT;
      taken_total <= '0;
      taken_mark  <= '0;
      closing     <= 1'b0;
      ring_vld    <= '0;
      pf_addr     <= '0;
      pf_vld      <= 1'b0;
      pf_byp      <= 1'b0;
    end else begin
      if (fire) begin
        ring_head   <= ring_head_next;
        ring_tail   <= ring_tail_next;
        free_total  <= free_total_next;
        taken_total <= taken_total_next;
        taken_mark  <= taken_mark_next;
        closing     <= closing_next;
        if (wr_en) begin
          ring_vld[wr_addr] <= 1'b1;
        end
      end
      pf_addr <= rd_addr;
      pf_vld  <= ring_vld[rd_addr];
      // forward a write that lands on the entry being prefetched
      pf_byp  <= fire && wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    pf_byp_data <= wr_data;
  end

endmodule

`default_nettype wire

/* hdl/buffer_pool_free_ring_top.sv */
// ----------------------------------------------------------------------------
// buffer_pool_free_ring_top
// Buffer pool manager over a free ring of DEPTH block indices.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall): operation and block_index. A word
//   moves on an edge with in_valid high and in_stall low.
//   Result channel (out_valid / out_stall): status, granted_index and
//   outstanding, one result word per request word, in request order.
//   Each request word passes through the input register and then the result
//   register. Throughput: one request per cycle while out_stall stays low. An
//   acquire reads one ring entry (prefetched from the ring RAM at the head)
//   and one checkout mark; a return reads one checkout mark.
//   A stalled result holds in the result register; the request waiting in
//   the input register holds too, and in_stall rises until the result
//   register can take a new word.
//   Reset: pool open, every block free, ring holds blocks 0..DEPTH-1 in order.
//   Ring entries never written read as their own position, so no clearing
//   pass runs; requests are taken straight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_free_ring_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bpfr_pkg::OP_W-1:0]      operation,
  input  wire logic [bpfr_pkg::BIDX_W-1:0]    block_index,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [bpfr_pkg::ST_W-1:0]      status,
  output logic      [bpfr_pkg::GRANT_W-1:0]   granted_index,
  output logic      [bpfr_pkg::OUTS_W-1:0]    outstanding
);

  logic           req_valid;
  bpfr_pkg::req_t req;
  bpfr_pkg::rsp_t rsp;
  logic           fire;
  logic           accept;

  assign fire     = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !fire;
  assign accept   = in_valid && !in_stall;

  bpfr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        req_valid <= 1'b1;
      end else if (fire) begin
        req_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.operation   <= operation;
      req.block_index <= block_index;
    end
    if (fire) begin
      status        <= rsp.status;
      granted_index <= rsp.granted_index;
      outstanding   <= rsp.outstanding;
    end
  end

endmodule

`default_nettype wire

/* hdl/bpfr_checker.sv */
// ----------------------------------------------------------------------------
// bpfr_checker
// Port-level checks of the buffer pool free ring.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buffer_pool_free_ring_top_assert.svh"

module bpfr_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [bpfr_pkg::ST_W-1:0]    status,
  input wire logic [bpfr_pkg::GRANT_W-1:0] granted_index,
  input wire logic [bpfr_pkg::OUTS_W-1:0]  outstanding
);

  // stalled result word holds
  `BPFR_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(granted_index) && $stable(outstanding), "stalled result changed")

  `BPFR_ASSERT_NOW(a_cnt_max, clk, rst, out_valid, 32'(outstanding) <= DEPTH, "outstanding above pool size")

  `BPFR_ASSERT_NOW(a_grant_zero, clk, rst, out_valid && status != bpfr_pkg::ST_OK, granted_index == '0, "grant on failed request")

  // back-to-back results differ by at most one checkout
  `BPFR_ASSERT_NEXT(a_cnt_step, clk, rst, out_valid && !out_stall, !out_valid || outstanding == $past(outstanding) || outstanding == $past(outstanding) + 5'd1 || outstanding == $past(outstanding) - 5'd1, "outstanding jumped")

endmodule

bind buffer_pool_free_ring_top bpfr_checker #(
  .DEPTH (DEPTH)
) u_bpfr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .granted_index (granted_index),
  .outstanding   (outstanding)
);

`default_nettype wire

/* tb/buffer_pool_free_ring_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buffer_pool_free_ring_top_test
// Self-checking bench for the buffer pool free ring. A queue of request
// words drives the block in random bursts while the result side stalls on
// its own pattern. A built-in pool predictor answers each accepted request,
// and every result word is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_free_ring_top_test;

  localparam int POOL_DEPTH = 16;
  localparam logic [bpfr_pkg::OP_W-1:0] OP_UNDEF = 2'd3;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int MAX_REPORTS = 10;

  typedef logic [bpfr_pkg::BIDX_W-1:0] bidx_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bpfr_pkg::OP_W-1:0] operation = '0;
  logic [bpfr_pkg::BIDX_W-1:0] block_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bpfr_pkg::ST_W-1:0] status;
  logic [bpfr_pkg::GRANT_W-1:0] granted_index;
  logic [bpfr_pkg::OUTS_W-1:0] outstanding;

  buffer_pool_free_ring_top #(
    .DEPTH(POOL_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .block_index(block_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .granted_index(granted_index),
    .outstanding(outstanding)
  );

  // Pool shadow state
  logic [bpfr_pkg::GRANT_W-1:0] free_slots[POOL_DEPTH];
  int slot_head;
  int slot_tail;
  int free_count;
  int out_count;
  bit [POOL_DEPTH-1:0] checked_out;
  bit pool_closed;

  bpfr_pkg::req_t pending_requests[$];
  bpfr_pkg::rsp_t predicted_answers[$];
  int requests_total;
  int requests_taken = 0;
  int mismatch_count = 0;
  bit req_accepted = 1'b0;

  function automatic bpfr_pkg::rsp_t predict_pool_answer(logic [bpfr_pkg::OP_W-1:0] op,
                                                         logic [bpfr_pkg::BIDX_W-1:0] idx);
    bpfr_pkg::rsp_t ans;
    int blk;
    ans = '0;
    ans.status = bpfr_pkg::ST_OK;
    case (op)
      bpfr_pkg::OP_ACQUIRE: begin
        if (pool_closed) begin
          ans.status = bpfr_pkg::ST_CLOSING;
        end else if (free_count == 0) begin
          ans.status = bpfr_pkg::ST_EMPTY;
        end else begin
          blk = int'(free_slots[slot_head]);
          slot_head = (slot_head + 1) % POOL_DEPTH;
          free_count--;
          // a stale entry still costs the pop
          if (blk >= POOL_DEPTH || checked_out[blk]) begin
            ans.status = bpfr_pkg::ST_EMPTY;
          end else begin
            checked_out[blk] = 1'b1;
            out_count++;
            ans.granted_index = blk[bpfr_pkg::GRANT_W-1:0];
          end
        end
      end
      bpfr_pkg::OP_RETURN: begin
        if (pool_closed) begin
          ans.status = bpfr_pkg::ST_CLOSING;
        end else if (idx >= POOL_DEPTH) begin
          ans.status = bpfr_pkg::ST_UNKNOWN;
        end else if (!checked_out[idx] || out_count == 0) begin
          ans.status = bpfr_pkg::ST_NOT_OUT;
        end else begin
          checked_out[idx] = 1'b0;
          out_count--;
          if (free_count < POOL_DEPTH) begin
            free_slots[slot_tail] = idx[bpfr_pkg::GRANT_W-1:0];
            slot_tail = (slot_tail + 1) % POOL_DEPTH;
            free_count++;
          end
        end
      end
      bpfr_pkg::OP_CLOSE: pool_closed = 1'b1;
      default: ;
    endcase
    ans.outstanding = out_count[bpfr_pkg::OUTS_W-1:0];
    return ans;
  endfunction

  task automatic queue_request(logic [bpfr_pkg::OP_W-1:0] op,
                               logic [bpfr_pkg::BIDX_W-1:0] idx);
    bpfr_pkg::req_t r;
    r.operation = op;
    r.block_index = idx;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("** buffer_pool_free_ring_top: FAILED **");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    int acq_pct;
    int pick;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      free_slots[i] = i[bpfr_pkg::GRANT_W-1:0];
    end
    slot_head = 0;
    slot_tail = 0;
    free_count = POOL_DEPTH;
    out_count = 0;
    checked_out = '0;
    pool_closed = 1'b0;

    // directed: bad returns on an untouched pool, an undefined op, drain past empty, then returns with a repeat
    queue_request(bpfr_pkg::OP_RETURN, 8'd0);
    queue_request(bpfr_pkg::OP_RETURN, 8'hFF);
    queue_request(bpfr_pkg::OP_RETURN, 8'd16);
    queue_request(OP_UNDEF, 8'hAA);
    for (int i = 0; i <= POOL_DEPTH; i++) begin
      queue_request(bpfr_pkg::OP_ACQUIRE, bidx_t'($urandom_range(255)));
    end
    queue_request(bpfr_pkg::OP_RETURN, 8'd15);
    queue_request(bpfr_pkg::OP_RETURN, 8'd15);
    queue_request(bpfr_pkg::OP_RETURN, 8'd0);

    // random: swing between acquire-heavy and return-heavy stretches
    acq_pct = 50;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) begin
        acq_pct = $urandom_range(85, 15);
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        queue_request(OP_UNDEF, bidx_t'($urandom_range(255)));
      end else if (pick < 8) begin
        queue_request(bpfr_pkg::OP_RETURN, bidx_t'($urandom_range(255, POOL_DEPTH)));
      end else if ($urandom_range(99) < acq_pct) begin
        queue_request(bpfr_pkg::OP_ACQUIRE, bidx_t'($urandom_range(255)));
      end else begin
        queue_request(bpfr_pkg::OP_RETURN, bidx_t'($urandom_range(POOL_DEPTH - 1)));
      end
    end

    // closing is sticky, so it comes last
    queue_request(bpfr_pkg::OP_CLOSE, bidx_t'($urandom_range(255)));
    queue_request(bpfr_pkg::OP_ACQUIRE, 8'd0);
    queue_request(bpfr_pkg::OP_RETURN, 8'd3);
    queue_request(bpfr_pkg::OP_RETURN, 8'd200);
    queue_request(bpfr_pkg::OP_CLOSE, 8'd0);
    queue_request(OP_UNDEF, 8'd0);
    queue_request(bpfr_pkg::OP_ACQUIRE, 8'd0);
    requests_total = pending_requests.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests_taken < requests_total) @(posedge clk);
    while (predicted_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** buffer_pool_free_ring_top: PASSED **");
    end else begin
      $display("** buffer_pool_free_ring_top: FAILED **");
    end
    $finish;
  end

  // Request driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !req_accepted) begin
        // hold the stalled word
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        bpfr_pkg::req_t r;
        r = pending_requests.pop_front();
        operation <= r.operation;
        block_index <= r.block_index;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(99) < 30) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
      req_accepted = 1'b0;
    end
  end

  // Result stall pattern, with one long hold-off to back the block up
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && requests_taken >= 700) begin
        hold_left = 120;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2);
        mode_left = $urandom_range(100, 20);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(99) < 25);
          default: out_stall <= ($urandom_range(99) < 70);
        endcase
      end
    end
  end

  // Accept requests into the predictor and check result words
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predicted_answers.insert(predicted_answers.size(),
                                 predict_pool_answer(operation, block_index));
        requests_taken++;
        req_accepted = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (predicted_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result word status=%0d granted=%0d outstanding=%0d",
                     $realtime, status, granted_index, outstanding);
          end
        end else begin
          bpfr_pkg::rsp_t want;
          want = predicted_answers.pop_front();
          if (status !== want.status || granted_index !== want.granted_index ||
              outstanding !== want.outstanding) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: result mismatch exp status=%0d granted=%0d outstanding=%0d",
                       $realtime, want.status, want.granted_index, want.outstanding);
              $display("%0t:                 got status=%0d granted=%0d outstanding=%0d",
                       $realtime, status, granted_index, outstanding);
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
